FILE: rtl/rmq_pkg.sv
// Shared constants and types for the rotation-matrix-to-quaternion pipeline.
// Fixed-point format, lane indexes and the stage payload structs.
// No dependencies.
package rmq_pkg;

    localparam int FRAC_BITS  = 30;
    localparam int MAG_W      = 31;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = MAG_W;

    localparam logic signed [35:0] ONE_FX    = 36'sd1 <<< FRAC_BITS;
    localparam logic signed [35:0] TRACE_MIN =
        36'((ONE_FX + 36'sd50000000) / 36'sd100000000);
    localparam logic [MAG_W-1:0]   MAG_MAX   = '1;

    localparam logic [1:0] LANE_W = 2'd0;
    localparam logic [1:0] LANE_X = 2'd1;
    localparam logic [1:0] LANE_Y = 2'd2;
    localparam logic [1:0] LANE_Z = 2'd3;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } trans_t;

    typedef struct packed {
        logic [63:0] v;
        logic [63:0] r;
    } sqrt_t;

    typedef struct packed {
        logic [32:0]      rem;
        logic [MAG_W-1:0] low;
        logic [MAG_W-1:0] q;
    } div_lane_t;

    typedef struct packed {
        logic [1:0]        qlane;
        logic              degen;
        logic [3:0][33:0]  num;
        trans_t            trans;
    } front_side_t;

    typedef struct packed {
        logic [32:0]      divisor;
        logic [MAG_W-1:0] quarter;
        logic [3:0]       ovf;
        logic [3:0]       neg;
        logic [1:0]       qlane;
        logic             degen;
        trans_t           trans;
    } div1_side_t;

    typedef struct packed {
        logic [3:0][MAG_W-1:0] mag;
        logic [3:0]            neg;
        logic                  degen;
        trans_t                trans;
    } mag_side_t;

    typedef struct packed {
        logic [32:0] divisor;
        logic [3:0]  neg;
        logic        degen;
        trans_t      trans;
    } div2_side_t;

    typedef struct packed {
        logic [3:0][31:0] quat;
        trans_t           trans;
        logic             degen;
    } result_t;

endpackage

FILE: rtl/rmq_sqrt_step.sv
// One iteration of the bit-pair integer square root (64-bit radicand).
// Depends on rmq_pkg.
module rmq_sqrt_step (
    input  logic [4:0]     step_idx,
    input  rmq_pkg::sqrt_t stage_in,
    output rmq_pkg::sqrt_t stage_out
);
    import rmq_pkg::*;

    logic [63:0] bit_val;
    logic [63:0] trial;

    always_comb begin
        bit_val = 64'd1 << {5'(5'd31 - step_idx), 1'b0};
        trial   = stage_in.r + bit_val;
        if (stage_in.v >= trial) begin
            stage_out.v = stage_in.v - trial;
            stage_out.r = (stage_in.r >> 1) + bit_val;
        end else begin
            stage_out.v = stage_in.v;
            stage_out.r = stage_in.r >> 1;
        end
    end

endmodule

FILE: rtl/rmq_div_step.sv
// One restoring-division step: one quotient bit per call.
// Depends on rmq_pkg.
module rmq_div_step (
    input  rmq_pkg::div_lane_t lane_in,
    input  logic [32:0]        divisor,
    output rmq_pkg::div_lane_t lane_out
);
    import rmq_pkg::*;

    logic [33:0] shifted;
    logic [33:0] diff;
    logic        take;

    always_comb begin
        shifted      = {lane_in.rem, lane_in.low[MAG_W-1]};
        diff         = shifted - {1'b0, divisor};
        take         = shifted >= {1'b0, divisor};
        lane_out.rem = take ? diff[32:0] : shifted[32:0];
        lane_out.low = {lane_in.low[MAG_W-2:0], 1'b0};
        lane_out.q   = {lane_in.q[MAG_W-2:0], take};
    end

endmodule

FILE: rtl/rmq_out_buf.sv
// Output register plus one skid entry; decouples pipeline advance from m_ready.
// Depends on rmq_pkg.
module rmq_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  rmq_pkg::result_t in_data,
    output logic             in_ready,
    output logic             out_valid,
    output rmq_pkg::result_t out_data,
    input  logic             out_ready
);
    import rmq_pkg::*;

    logic    out_v_reg;
    logic    skid_v_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign in_ready  = !skid_v_reg;
    assign out_valid = out_v_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (!out_v_reg || out_ready) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= in_valid;
            end
        end else if (in_valid && !skid_v_reg) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_v_reg || out_ready) begin
            out_data_reg <= skid_v_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_v_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

FILE: rtl/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to unit quaternion (trace / largest-diagonal method).
// Depends on rmq_pkg, rmq_sqrt_step, rmq_div_step, rmq_out_buf.
//
// Usage:
//   Input channel s_*: nine rotation words (Q2.30) and three translation
//   words (Q16.16) of a column-major pose matrix, one transfer per item.
//   Output channel m_*: normalized (W, -X, -Y, -Z) in Q2.30, translation
//   copied, and a degenerate flag that zeroes the quaternion.
//   Throughput: one item per cycle while s_ready is high. Every stage holds one item; the chain is
//   two 32-step square roots and two 31-step divisions, one step per stage.
//   Depth: 134 register stages, from the input register to the output register.
//   Stall: the pipeline advances as long as the skid entry behind the output
//   register is empty, so s_ready stays high while one result waits; when
//   the receiver holds m_ready low longer, the skid fills and s_ready drops.
//   Nothing is dropped or repeated.
//   Reset: synchronous, active low; clears all valid bits, s_ready is high
//   in the first cycle after reset.
module rotation_matrix_to_quaternion_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_word_0,
    input  logic signed [31:0] s_word_1,
    input  logic signed [31:0] s_word_2,
    input  logic signed [31:0] s_word_4,
    input  logic signed [31:0] s_word_5,
    input  logic signed [31:0] s_word_6,
    input  logic signed [31:0] s_word_8,
    input  logic signed [31:0] s_word_9,
    input  logic signed [31:0] s_word_10,
    input  logic signed [31:0] s_in_trans_x,
    input  logic signed [31:0] s_in_trans_y,
    input  logic signed [31:0] s_in_trans_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_quat_w,
    output logic signed [31:0] m_quat_x,
    output logic signed [31:0] m_quat_y,
    output logic signed [31:0] m_quat_z,
    output logic signed [31:0] m_trans_x,
    output logic signed [31:0] m_trans_y,
    output logic signed [31:0] m_trans_z,
    output logic               m_degenerate
);
    import rmq_pkg::*;

    logic ce;

    logic                    in_v_reg;
    logic [SQRT_STEPS:0]     sq1_v_reg;
    logic [DIV_STEPS:0]      dv1_v_reg;
    logic                    mag_v_reg;
    logic                    prod_v_reg;
    logic [SQRT_STEPS:0]     sq2_v_reg;
    logic [DIV_STEPS:0]      dv2_v_reg;

    logic [8:0][31:0]        mat_reg;
    trans_t                  in_trans_reg;

    sqrt_t                   sq1_reg   [0:SQRT_STEPS];
    sqrt_t                   sq1_next  [1:SQRT_STEPS];
    front_side_t             fs_reg    [0:SQRT_STEPS];
    sqrt_t                   sq1_init;
    front_side_t             fs_next;

    div_lane_t               dv1_reg   [0:DIV_STEPS][0:3];
    div_lane_t               dv1_next  [1:DIV_STEPS][0:3];
    div1_side_t              d1s_reg   [0:DIV_STEPS];
    div_lane_t               dv1_init  [0:3];
    div1_side_t              d1s_next;

    mag_side_t               ms_reg;
    mag_side_t               ms_next;
    logic [3:0][2*MAG_W-1:0] prod_reg;
    mag_side_t               ps_reg;

    sqrt_t                   sq2_reg   [0:SQRT_STEPS];
    sqrt_t                   sq2_next  [1:SQRT_STEPS];
    mag_side_t               s2s_reg   [0:SQRT_STEPS];

    div_lane_t               dv2_reg   [0:DIV_STEPS][0:3];
    div_lane_t               dv2_next  [1:DIV_STEPS][0:3];
    div2_side_t              d2s_reg   [0:DIV_STEPS];
    div_lane_t               dv2_init  [0:3];
    div2_side_t              d2s_next;

    result_t                 res_next;
    result_t                 buf_out;

    assign s_ready = ce;

    // valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg   <= 1'b0;
            sq1_v_reg  <= '0;
            dv1_v_reg  <= '0;
            mag_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            sq2_v_reg  <= '0;
            dv2_v_reg  <= '0;
        end else if (ce) begin
            in_v_reg   <= s_valid;
            sq1_v_reg  <= {sq1_v_reg[SQRT_STEPS-1:0], in_v_reg};
            dv1_v_reg  <= {dv1_v_reg[DIV_STEPS-1:0], sq1_v_reg[SQRT_STEPS]};
            mag_v_reg  <= dv1_v_reg[DIV_STEPS];
            prod_v_reg <= mag_v_reg;
            sq2_v_reg  <= {sq2_v_reg[SQRT_STEPS-1:0], prod_v_reg};
            dv2_v_reg  <= {dv2_v_reg[DIV_STEPS-1:0], sq2_v_reg[SQRT_STEPS]};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mat_reg      <= {s_word_10, s_word_9, s_word_8, s_word_6, s_word_5,
                             s_word_4, s_word_2, s_word_1, s_word_0};
            in_trans_reg <= {s_in_trans_x, s_in_trans_y, s_in_trans_z};
        end
    end

    // branch select and radicand
    always_comb begin
        logic signed [31:0] m0, m1, m2, m4, m5, m6, m8, m9, m10;
        logic signed [35:0] t;
        logic signed [35:0] arg;
        logic signed [33:0] d96, d28, d41, s41, s28, s96;
        m0  = $signed(mat_reg[0]);
        m1  = $signed(mat_reg[1]);
        m2  = $signed(mat_reg[2]);
        m4  = $signed(mat_reg[3]);
        m5  = $signed(mat_reg[4]);
        m6  = $signed(mat_reg[5]);
        m8  = $signed(mat_reg[6]);
        m9  = $signed(mat_reg[7]);
        m10 = $signed(mat_reg[8]);
        t   = ONE_FX + 36'(m0) + 36'(m5) + 36'(m10);
        d96 = 34'(m9) - 34'(m6);
        d28 = 34'(m2) - 34'(m8);
        d41 = 34'(m4) - 34'(m1);
        s41 = 34'(m4) + 34'(m1);
        s28 = 34'(m2) + 34'(m8);
        s96 = 34'(m9) + 34'(m6);
        fs_next.num = '0;
        if (t > TRACE_MIN) begin
            fs_next.qlane       = LANE_W;
            arg                 = t;
            fs_next.num[LANE_X] = d96;
            fs_next.num[LANE_Y] = d28;
            fs_next.num[LANE_Z] = d41;
        end else if (m0 > m5 && m0 > m10) begin
            fs_next.qlane       = LANE_X;
            arg                 = ONE_FX + 36'(m0) - 36'(m5) - 36'(m10);
            fs_next.num[LANE_W] = d96;
            fs_next.num[LANE_Y] = s41;
            fs_next.num[LANE_Z] = s28;
        end else if (m5 > m10) begin
            fs_next.qlane       = LANE_Y;
            arg                 = ONE_FX + 36'(m5) - 36'(m0) - 36'(m10);
            fs_next.num[LANE_W] = d28;
            fs_next.num[LANE_X] = s41;
            fs_next.num[LANE_Z] = s96;
        end else begin
            fs_next.qlane       = LANE_Z;
            arg                 = ONE_FX + 36'(m10) - 36'(m0) - 36'(m5);
            fs_next.num[LANE_W] = d41;
            fs_next.num[LANE_X] = s28;
            fs_next.num[LANE_Y] = s96;
        end
        fs_next.degen = arg <= 36'sd0;
        fs_next.trans = in_trans_reg;
        sq1_init.v    = $unsigned(64'(arg)) << FRAC_BITS;
        sq1_init.r    = '0;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sq1_reg[0] <= sq1_init;
            fs_reg[0]  <= fs_next;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq1
        rmq_sqrt_step u_step (
            .step_idx  (5'(k)),
            .stage_in  (sq1_reg[k]),
            .stage_out (sq1_next[k+1])
        );
        always_ff @(posedge aclk) begin
            if (ce) begin
                sq1_reg[k+1] <= sq1_next[k+1];
                fs_reg[k+1]  <= fs_reg[k];
            end
        end
    end

    // quotient setup: magnitudes, signs, overflow
    always_comb begin
        logic [32:0]        s;
        logic signed [33:0] num_s;
        logic signed [33:0] abs_s;
        logic [32:0]        mag;
        logic [63:0]        dvd;
        logic               cneg;
        s = {sq1_reg[SQRT_STEPS].r[31:0], 1'b0};
        d1s_next.divisor = s;
        d1s_next.quarter = s[32:2];
        d1s_next.qlane   = fs_reg[SQRT_STEPS].qlane;
        d1s_next.degen   = fs_reg[SQRT_STEPS].degen;
        d1s_next.trans   = fs_reg[SQRT_STEPS].trans;
        for (int i = 0; i < 4; i++) begin
            num_s  = $signed(fs_reg[SQRT_STEPS].num[i]);
            abs_s  = (num_s < 34'sd0) ? -num_s : num_s;
            mag    = abs_s[32:0];
            dvd    = 64'(mag) << FRAC_BITS;
            cneg   = (2'(i) == fs_reg[SQRT_STEPS].qlane) ? 1'b0 : (num_s < 34'sd0);
            d1s_next.neg[i] = (2'(i) == LANE_W) ? cneg : !cneg;
            d1s_next.ovf[i] = (65'(mag) << FRAC_BITS) >= (65'(s) << MAG_W);
            dv1_init[i].rem = dvd[63:MAG_W];
            dv1_init[i].low = dvd[MAG_W-1:0];
            dv1_init[i].q   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv1_reg[0] <= dv1_init;
            d1s_reg[0] <= d1s_next;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv1
        for (genvar j = 0; j < 4; j++) begin : g_lane
            rmq_div_step u_step (
                .lane_in  (dv1_reg[k][j]),
                .divisor  (d1s_reg[k].divisor),
                .lane_out (dv1_next[k+1][j])
            );
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                dv1_reg[k+1] <= dv1_next[k+1];
                d1s_reg[k+1] <= d1s_reg[k];
            end
        end
    end

    // saturated raw components
    always_comb begin
        ms_next.neg   = d1s_reg[DIV_STEPS].neg;
        ms_next.degen = d1s_reg[DIV_STEPS].degen;
        ms_next.trans = d1s_reg[DIV_STEPS].trans;
        for (int i = 0; i < 4; i++) begin
            if (2'(i) == d1s_reg[DIV_STEPS].qlane) begin
                ms_next.mag[i] = d1s_reg[DIV_STEPS].quarter;
            end else if (d1s_reg[DIV_STEPS].ovf[i]) begin
                ms_next.mag[i] = MAG_MAX;
            end else begin
                ms_next.mag[i] = dv1_reg[DIV_STEPS][i].q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ms_reg <= ms_next;
            for (int i = 0; i < 4; i++) begin
                prod_reg[i] <= (2*MAG_W)'(ms_reg.mag[i]) * (2*MAG_W)'(ms_reg.mag[i]);
            end
            ps_reg       <= ms_reg;
            sq2_reg[0].v <= 64'(prod_reg[0]) + 64'(prod_reg[1])
                          + 64'(prod_reg[2]) + 64'(prod_reg[3]);
            sq2_reg[0].r <= '0;
            s2s_reg[0]   <= ps_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq2
        rmq_sqrt_step u_step (
            .step_idx  (5'(k)),
            .stage_in  (sq2_reg[k]),
            .stage_out (sq2_next[k+1])
        );
        always_ff @(posedge aclk) begin
            if (ce) begin
                sq2_reg[k+1] <= sq2_next[k+1];
                s2s_reg[k+1] <= s2s_reg[k];
            end
        end
    end

    // normalization setup
    always_comb begin
        logic [31:0] n;
        logic [63:0] dvd;
        n = sq2_reg[SQRT_STEPS].r[31:0];
        d2s_next.divisor = {1'b0, n};
        d2s_next.neg     = s2s_reg[SQRT_STEPS].neg;
        d2s_next.degen   = s2s_reg[SQRT_STEPS].degen || (n == 32'd0);
        d2s_next.trans   = s2s_reg[SQRT_STEPS].trans;
        for (int i = 0; i < 4; i++) begin
            dvd             = 64'(s2s_reg[SQRT_STEPS].mag[i]) << FRAC_BITS;
            dv2_init[i].rem = dvd[63:MAG_W];
            dv2_init[i].low = dvd[MAG_W-1:0];
            dv2_init[i].q   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dv2_reg[0] <= dv2_init;
            d2s_reg[0] <= d2s_next;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dv2
        for (genvar j = 0; j < 4; j++) begin : g_lane
            rmq_div_step u_step (
                .lane_in  (dv2_reg[k][j]),
                .divisor  (d2s_reg[k].divisor),
                .lane_out (dv2_next[k+1][j])
            );
        end
        always_ff @(posedge aclk) begin
            if (ce) begin
                dv2_reg[k+1] <= dv2_next[k+1];
                d2s_reg[k+1] <= d2s_reg[k];
            end
        end
    end

    always_comb begin
        logic [31:0] qv;
        res_next.trans = d2s_reg[DIV_STEPS].trans;
        res_next.degen = d2s_reg[DIV_STEPS].degen;
        for (int i = 0; i < 4; i++) begin
            qv = {1'b0, dv2_reg[DIV_STEPS][i].q};
            if (d2s_reg[DIV_STEPS].degen) begin
                res_next.quat[i] = '0;
            end else if (d2s_reg[DIV_STEPS].neg[i]) begin
                res_next.quat[i] = -qv;
            end else begin
                res_next.quat[i] = qv;
            end
        end
    end

    rmq_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dv2_v_reg[DIV_STEPS]),
        .in_data   (res_next),
        .in_ready  (ce),
        .out_valid (m_valid),
        .out_data  (buf_out),
        .out_ready (m_ready)
    );

    assign m_quat_w     = $signed(buf_out.quat[LANE_W]);
    assign m_quat_x     = $signed(buf_out.quat[LANE_X]);
    assign m_quat_y     = $signed(buf_out.quat[LANE_Y]);
    assign m_quat_z     = $signed(buf_out.quat[LANE_Z]);
    assign m_trans_x    = $signed(buf_out.trans.x);
    assign m_trans_y    = $signed(buf_out.trans.y);
    assign m_trans_z    = $signed(buf_out.trans.z);
    assign m_degenerate = buf_out.degen;

endmodule

FILE: rtl/rmq_checker.sv
// Port-level checks for rotation_matrix_to_quaternion_core, attached by bind.
// Depends on the top-level port list only.
module rmq_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_quat_w,
    input logic signed [31:0] m_quat_x,
    input logic signed [31:0] m_quat_y,
    input logic signed [31:0] m_quat_z,
    input logic signed [31:0] m_trans_x,
    input logic               m_degenerate
);
    localparam logic signed [31:0] UNIT = 32'sh40000000;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quat_w) && $stable(m_trans_x))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset did not clear the pipeline");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            m_quat_w == 32'sd0 && m_quat_x == 32'sd0 && m_quat_y == 32'sd0
            && m_quat_z == 32'sd0)
        else $error("degenerate result carries a quaternion");

    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |->
            m_quat_w != 32'sd0 || m_quat_x != 32'sd0 || m_quat_y != 32'sd0
            || m_quat_z != 32'sd0)
        else $error("normalized quaternion is zero");

    a_unit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_quat_w <= UNIT && m_quat_w >= -UNIT && m_quat_x <= UNIT
            && m_quat_x >= -UNIT && m_quat_y <= UNIT && m_quat_y >= -UNIT
            && m_quat_z <= UNIT && m_quat_z >= -UNIT)
        else $error("component above unit magnitude");

endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (.*);

FILE: test/rotation_matrix_to_quaternion_core_tb.sv
// Testbench for rotation_matrix_to_quaternion_core: drives pose matrices, predicts
// the normalized quaternion and translation in fixed point, and checks each result.
// Depends on rmq_pkg and the core RTL.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_core_tb;
    import rmq_pkg::*;

    localparam int        CYCLE_LIMIT = 600000;
    localparam int        DRAIN_CYCLES = 160;
    localparam longint    ONE = longint'(1) << FRAC_BITS;
    localparam longint    TRACE_THRESH = (ONE + 50000000) / 100000000;
    localparam longint    SAT_LIM = 64'sd2147483647;

    typedef struct {
        logic signed [31:0] m0, m1, m2, m4, m5, m6, m8, m9, m10;
        logic signed [31:0] tx, ty, tz;
    } pose_t;

    typedef struct {
        logic [31:0] w, x, y, z, tx, ty, tz;
        logic        degen;
    } quat_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_word_0 = '0, s_word_1 = '0, s_word_2 = '0;
    logic signed [31:0] s_word_4 = '0, s_word_5 = '0, s_word_6 = '0;
    logic signed [31:0] s_word_8 = '0, s_word_9 = '0, s_word_10 = '0;
    logic signed [31:0] s_in_trans_x = '0, s_in_trans_y = '0, s_in_trans_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_quat_w, m_quat_x, m_quat_y, m_quat_z;
    logic signed [31:0] m_trans_x, m_trans_y, m_trans_z;
    logic               m_degenerate;

    quat_result_t expected_quats[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           hold_request = 1'b0;

    rotation_matrix_to_quaternion_core i_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint fixed_div(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : num;
        q = (mag << FRAC_BITS) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp31(longint v);
        if (v > SAT_LIM) return SAT_LIM;
        if (v < -SAT_LIM) return -SAT_LIM;
        return v;
    endfunction

    function automatic quat_result_t quat_from_pose(pose_t p);
        quat_result_t    res;
        longint          m0, m1, m2, m4, m5, m6, m8, m9, m10;
        longint          tr, arg, w, x, y, z, quarter;
        longint          c[4];
        longint unsigned s, sum, n, a;
        int              branch;
        bit              degen;
        m0 = longint'(p.m0); m1 = longint'(p.m1); m2 = longint'(p.m2);
        m4 = longint'(p.m4); m5 = longint'(p.m5); m6 = longint'(p.m6);
        m8 = longint'(p.m8); m9 = longint'(p.m9); m10 = longint'(p.m10);
        degen = 1'b0;
        c = '{0, 0, 0, 0};
        tr = ONE + m0 + m5 + m10;
        if (tr > TRACE_THRESH) begin
            branch = 3; arg = tr;
        end else if (m0 > m5 && m0 > m10) begin
            branch = 0; arg = ONE + m0 - m5 - m10;
        end else if (m5 > m10) begin
            branch = 1; arg = ONE + m5 - m0 - m10;
        end else begin
            branch = 2; arg = ONE + m10 - m0 - m5;
        end
        if (arg <= 0) begin
            degen = 1'b1;
        end else begin
            s = 2 * int_sqrt(longint'(arg) << FRAC_BITS);
            quarter = s >> 2;
            case (branch)
                3: begin
                    x = fixed_div(m9 - m6, s); y = fixed_div(m2 - m8, s);
                    z = fixed_div(m4 - m1, s); w = quarter;
                end
                0: begin
                    x = quarter; y = fixed_div(m4 + m1, s);
                    z = fixed_div(m2 + m8, s); w = fixed_div(m9 - m6, s);
                end
                1: begin
                    x = fixed_div(m4 + m1, s); y = quarter;
                    z = fixed_div(m9 + m6, s); w = fixed_div(m2 - m8, s);
                end
                default: begin
                    x = fixed_div(m2 + m8, s); y = fixed_div(m9 + m6, s);
                    z = quarter; w = fixed_div(m4 - m1, s);
                end
            endcase
            c[0] = clamp31(w); c[1] = clamp31(-x); c[2] = clamp31(-y); c[3] = clamp31(-z);
            sum = 0;
            for (int i = 0; i < 4; i++) begin
                a = (c[i] < 0) ? longint'(-c[i]) : c[i];
                sum += a * a;
            end
            n = int_sqrt(sum);
            if (n == 0) begin
                degen = 1'b1;
            end else begin
                for (int i = 0; i < 4; i++) c[i] = fixed_div(c[i], n);
            end
        end
        if (degen) c = '{0, 0, 0, 0};
        res.w = c[0][31:0]; res.x = c[1][31:0]; res.y = c[2][31:0]; res.z = c[3][31:0];
        res.tx = p.tx; res.ty = p.ty; res.tz = p.tz;
        res.degen = degen;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_pose(pose_t p, int gap);
        @(negedge aclk);
        s_word_0 = p.m0; s_word_1 = p.m1; s_word_2 = p.m2;
        s_word_4 = p.m4; s_word_5 = p.m5; s_word_6 = p.m6;
        s_word_8 = p.m8; s_word_9 = p.m9; s_word_10 = p.m10;
        s_in_trans_x = p.tx; s_in_trans_y = p.ty; s_in_trans_z = p.tz;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        expected_quats.insert(expected_quats.size(), quat_from_pose(p));
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // receiver: random stalls, plus a long hold on request
    initial begin
        int hold;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready = 1'b0;
                for (hold = 0; hold < 400; hold++) @(negedge aclk);
            end
            m_ready = ($urandom_range(99) < 70) ? 1'b1 : (pick_gap() == 0);
            if ($urandom_range(99) < 3) begin
                m_ready = 1'b0;
                repeat ($urandom_range(40, 10)) @(negedge aclk);
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        quat_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_quats.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                e = expected_quats.pop_front();
                check_field("quat_w", e.w, m_quat_w);
                check_field("quat_x", e.x, m_quat_x);
                check_field("quat_y", e.y, m_quat_y);
                check_field("quat_z", e.z, m_quat_z);
                check_field("trans_x", e.tx, m_trans_x);
                check_field("trans_y", e.ty, m_trans_y);
                check_field("trans_z", e.tz, m_trans_z);
                check_field("degenerate", 32'(e.degen), 32'(m_degenerate));
            end
        end
    end

    function automatic pose_t diag_pose(longint d0, longint d5, longint d10);
        pose_t p;
        p = '{default: '0};
        p.m0 = 32'(d0); p.m5 = 32'(d5); p.m10 = 32'(d10);
        return p;
    endfunction

    function automatic pose_t raw_pose();
        pose_t p;
        p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return p;
    endfunction

    function automatic real unit_rand();
        return $urandom / 4294967295.0 * 2.0 - 1.0;
    endfunction

    // proper rotation from a random unit quaternion; small w hits the diagonal branches
    function automatic pose_t rotation_pose();
        pose_t p;
        real   w, x, y, z, nrm, sc;
        w = unit_rand(); x = unit_rand(); y = unit_rand(); z = unit_rand();
        if ($urandom_range(3) == 0) w = w * 1.0e-3;
        nrm = $sqrt(w * w + x * x + y * y + z * z);
        if (nrm < 1.0e-6) begin
            w = 1.0; nrm = 1.0;
        end
        w /= nrm; x /= nrm; y /= nrm; z /= nrm;
        sc = 1.0 * ONE;
        p.m0  = $rtoi(sc * (1.0 - 2.0 * (y * y + z * z)));
        p.m1  = $rtoi(sc * 2.0 * (x * y + z * w));
        p.m2  = $rtoi(sc * 2.0 * (x * z - y * w));
        p.m4  = $rtoi(sc * 2.0 * (x * y - z * w));
        p.m5  = $rtoi(sc * (1.0 - 2.0 * (x * x + z * z)));
        p.m6  = $rtoi(sc * 2.0 * (y * z + x * w));
        p.m8  = $rtoi(sc * 2.0 * (x * z + y * w));
        p.m9  = $rtoi(sc * 2.0 * (y * z - x * w));
        p.m10 = $rtoi(sc * (1.0 - 2.0 * (x * x + y * y)));
        p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
        return p;
    endfunction

    function automatic pose_t mixed_pose();
        pose_t p;
        int    r;
        r = $urandom_range(99);
        if (r < 70) return rotation_pose();
        if (r < 85) return raw_pose();
        // near the trace threshold
        p = rotation_pose();
        p.m10 = 32'(-ONE - longint'(p.m0) - longint'(p.m5) + $urandom_range(24));
        return p;
    endfunction

    task automatic test_directed();
        pose_t p;
        send_pose(diag_pose(ONE, ONE, ONE), pick_gap());
        send_pose(diag_pose(ONE, -ONE, -ONE), pick_gap());
        send_pose(diag_pose(-ONE, ONE, -ONE), pick_gap());
        send_pose(diag_pose(-ONE, -ONE, ONE), pick_gap());
        send_pose(diag_pose(0, 0, -ONE + TRACE_THRESH + 1), pick_gap());
        send_pose(diag_pose(0, 0, -ONE + TRACE_THRESH), pick_gap());
        send_pose(diag_pose(-ONE / 2, -ONE / 2, -ONE / 2), pick_gap());
        send_pose(diag_pose(-ONE, -ONE, -ONE), pick_gap());
        send_pose(diag_pose(0, 0, 0), pick_gap());
        p = '{default: 32'sh7fff_ffff};
        send_pose(p, pick_gap());
        p = '{default: 32'sh8000_0000};
        send_pose(p, pick_gap());
        p = '{default: 32'sh5555_5555};
        send_pose(p, 0);
        p = '{default: 32'shaaaa_aaaa};
        send_pose(p, 0);
        // large off-diagonals at a tiny trace: raw components saturate
        p = diag_pose(0, 0, -ONE + TRACE_THRESH + 1);
        p.m9 = 32'sh7fff_ffff; p.m6 = 32'sh8000_0000;
        p.m2 = 32'sh8000_0000; p.m8 = 32'sh7fff_ffff;
        p.m4 = 32'sh7fff_ffff; p.m1 = 32'sh8000_0000;
        send_pose(p, pick_gap());
        p = diag_pose(-ONE, -ONE, -ONE);
        p.m1 = 32'sh7fff_ffff; p.m4 = 32'sh7fff_ffff;
        send_pose(p, pick_gap());
        for (int i = 0; i < 4; i++) send_pose(rotation_pose(), pick_gap());
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_pose(mixed_pose(), pick_gap());
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 300; i++) send_pose(mixed_pose(), 0);
    endtask

    initial begin
        int drained;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_random(300);
        test_backpressure();
        test_random(330);
        @(negedge aclk);
        s_valid = 1'b0;
        drained = 0;
        while (expected_quats.size() != 0 && drained < 20000) begin
            @(posedge aclk);
            drained++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_quats.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/rmq_pkg.sv
rtl/rmq_sqrt_step.sv
rtl/rmq_div_step.sv
rtl/rmq_out_buf.sv
rtl/rotation_matrix_to_quaternion_core.sv
rtl/rmq_checker.sv
test/rotation_matrix_to_quaternion_core_tb.sv
